// ===== rtl/quaternion_slerp_defines.svh =====
// assertion macros shared by the quaternion slerp checker
`ifndef QUATERNION_SLERP_DEFINES_SVH
`define QUATERNION_SLERP_DEFINES_SVH

// property checked outside reset
`define QS_CHK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("quaternion_slerp port check failed");

// property checked at every edge, reset included
`define QS_CHK_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("quaternion_slerp reset check failed");

`endif

// ===== rtl/qslerp_pkg.sv =====
// constants, stage map and types of the quaternion slerp pipeline
`default_nettype none

package qslerp_pkg;

  localparam int COMP_BITS   = 16;
  localparam int BLEND_BITS  = 16;
  localparam int CORDIC_N    = 30;
  localparam int SQRT_N      = 31;
  localparam int DIV_N       = 31;

  localparam logic [BLEND_BITS-1:0] BLEND_ONE   = 16'd32768;
  localparam logic signed [33:0]    CORDIC_GAIN = 34'sd652032874;
  // 9999 * 2^30, limit of the linear fallback
  localparam logic [48:0]           LIN_LIMIT   = 49'd10736344498176;
  localparam logic [60:0]           ONE_Q60     = 61'd1 << 60;
  localparam logic signed [49:0]    ROUND_HALF  = 50'sd536870912;

  // arctangent table, Q.30
  localparam logic [29:0] ATAN_Q30 [CORDIC_N] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515,  30'd16775850,  30'd8388437,   30'd4194282,   30'd2097149,
    30'd1048575,   30'd524287,    30'd262143,    30'd131071,    30'd65535,
    30'd32767,     30'd16383,     30'd8191,      30'd4095,      30'd2047,
    30'd1023,      30'd511,       30'd255,       30'd127,       30'd63,
    30'd31,        30'd15,        30'd7,         30'd3,         30'd1
  };

  // stage map, index of the register stage
  localparam int ST_PROD  = 0;
  localparam int ST_SUM   = 1;
  localparam int ST_ABS   = 2;
  localparam int ST_SQ    = 3;
  localparam int ST_RAD   = 4;
  localparam int ST_SQRT0 = ST_RAD + 1;
  localparam int ST_VEC0  = ST_SQRT0 + SQRT_N;
  localparam int ST_ANG   = ST_VEC0 + CORDIC_N;
  localparam int ST_ROT0  = ST_ANG + 1;
  localparam int ST_CLAMP = ST_ROT0 + CORDIC_N;
  localparam int ST_DIV0  = ST_CLAMP + 1;
  localparam int ST_K     = ST_DIV0 + DIV_N;
  localparam int ST_MUL   = ST_K + 1;
  localparam int ST_ACC   = ST_MUL + 1;
  localparam int ST_SAT   = ST_ACC + 1;
  localparam int LATENCY  = ST_SAT + 1;
  localparam int SIDE_N   = ST_MUL;

  // data that rides along the pipeline with each beat
  typedef struct packed {
    logic [3:0][COMP_BITS-1:0] a;
    logic [3:0][COMP_BITS:0]   b;
    logic [BLEND_BITS-1:0]     t;
    logic                      lin;
    logic [29:0]               c30;
    logic [30:0]               sinom;
  } side_t;

endpackage

`default_nettype wire

// ===== rtl/quaternion_slerp.sv =====
// quaternion slerp, shortest arc, fully pipelined fixed point datapath
//
//  channel   ports                              handshake
//  input     in_a_*, in_b_*, in_blend           start high, busy low
//  result    out_w, out_x, out_y, out_z         out_valid strobe, one cycle
//
// one beat enters per cycle while busy is low; every beat passes through the chain
// of square root, two cordic and divider stages, one step each.
// busy is high during reset and the cycle after it, then stays low.
// results cannot be held off; each shows for one cycle under out_valid.
// synchronous reset clears the valid line only; beats in flight are dropped.
`default_nettype none

module quaternion_slerp import qslerp_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [COMP_BITS-1:0] in_a_w,
  input  logic signed [COMP_BITS-1:0] in_a_x,
  input  logic signed [COMP_BITS-1:0] in_a_y,
  input  logic signed [COMP_BITS-1:0] in_a_z,
  input  logic signed [COMP_BITS-1:0] in_b_w,
  input  logic signed [COMP_BITS-1:0] in_b_x,
  input  logic signed [COMP_BITS-1:0] in_b_y,
  input  logic signed [COMP_BITS-1:0] in_b_z,
  input  logic [BLEND_BITS-1:0]       in_blend,
  output logic                        out_valid,
  output logic signed [COMP_BITS-1:0] out_w,
  output logic signed [COMP_BITS-1:0] out_x,
  output logic signed [COMP_BITS-1:0] out_y,
  output logic signed [COMP_BITS-1:0] out_z
);

  logic                        busy_r;
  logic                        accept;
  logic [ST_SAT:0]             vld_r;
  logic signed [COMP_BITS-1:0] a_in [4];
  logic signed [COMP_BITS-1:0] b_in [4];
  side_t                       side_in;
  side_t                       side_r [SIDE_N];
  side_t                       side_abs_nxt;
  side_t                       side_vec_nxt;

  logic signed [31:0]          prod_r [4];
  logic signed [33:0]          sum_r;
  logic signed [35:0]          c_full;
  logic                        neg;
  logic [34:0]                 cabs;
  logic [48:0]                 lin_lhs;
  logic [59:0]                 sq_r;
  logic [60:0]                 rad_r;

  logic [61:0]                 rt_n_r [SQRT_N];
  logic [61:0]                 rt_q_r [SQRT_N];
  logic [30:0]                 sinom;

  logic signed [33:0]          vx_r [CORDIC_N];
  logic signed [33:0]          vy_r [CORDIC_N];
  logic signed [33:0]          vz_r [CORDIC_N];

  logic [16:0]                 w0;
  logic [16:0]                 w1;
  logic signed [51:0]          ap0;
  logic signed [51:0]          ap1;
  logic signed [35:0]          ang_r [2];

  logic signed [33:0]          rx_r [2][CORDIC_N];
  logic signed [33:0]          ry_r [2][CORDIC_N];
  logic signed [35:0]          rz_r [2][CORDIC_N];

  logic [30:0]                 clamp_nxt [2];
  logic [30:0]                 clamp_r [2];
  logic [31:0]                 dr_r [2][DIV_N];
  logic [30:0]                 dq_r [2][DIV_N];

  logic [16:0]                 wk0;
  logic [30:0]                 k_r [2];
  logic signed [48:0]          m_r [4][2];
  logic signed [49:0]          acc_sum [4];
  logic signed [19:0]          acc_r [4];
  logic signed [COMP_BITS-1:0] out_r [4];

  // command handshake
  assign accept = start & ~busy;
  assign busy   = busy_r | ~rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // valid bits follow the beats
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[ST_SAT-1:0], accept};
    end
  end

  assign a_in[0] = in_a_w;
  assign a_in[1] = in_a_x;
  assign a_in[2] = in_a_y;
  assign a_in[3] = in_a_z;
  assign b_in[0] = in_b_w;
  assign b_in[1] = in_b_x;
  assign b_in[2] = in_b_y;
  assign b_in[3] = in_b_z;

  // side data of the incoming beat, blend clamped to one
  always_comb begin
    side_in = '0;
    for (int j = 0; j < 4; j++) begin
      side_in.a[j] = a_in[j];
      side_in.b[j] = {b_in[j][COMP_BITS-1], b_in[j]};
    end
    side_in.t = (in_blend > BLEND_ONE) ? BLEND_ONE : in_blend;
  end

  // stage 2: fold dot product sign, linear test
  assign c_full  = {sum_r, 2'b00};
  assign neg     = sum_r[33];
  assign cabs    = neg ? 35'(-c_full) : 35'(c_full);
  assign lin_lhs = 49'(cabs) * 49'd10000;

  // side data updated at the sign fold stage
  always_comb begin
    side_abs_nxt = side_r[ST_ABS-1];
    for (int j = 0; j < 4; j++) begin
      side_abs_nxt.b[j] = neg ? 17'(-$signed(side_r[ST_ABS-1].b[j]))
                              : side_r[ST_ABS-1].b[j];
    end
    side_abs_nxt.lin = (lin_lhs > LIN_LIMIT);
    side_abs_nxt.c30 = cabs[29:0];
  end

  // side data picks up sin(omega) at the first vectoring stage
  always_comb begin
    side_vec_nxt       = side_r[ST_VEC0-1];
    side_vec_nxt.sinom = sinom;
  end

  // side line with the updates made at fixed stages
  always_ff @(posedge clk) begin
    side_r[0] <= side_in;
    for (int i = 1; i < SIDE_N; i++) begin
      if (i == ST_ABS) begin
        side_r[i] <= side_abs_nxt;
      end else if (i == ST_VEC0) begin
        side_r[i] <= side_vec_nxt;
      end else begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // stages 0 to 4: dot product, square, radicand
  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      prod_r[j] <= a_in[j] * b_in[j];
    end
    sum_r <= 34'(prod_r[0]) + 34'(prod_r[1]) + 34'(prod_r[2]) + 34'(prod_r[3]);
    sq_r  <= 60'(side_r[ST_ABS].c30) * 60'(side_r[ST_ABS].c30);
    rad_r <= ONE_Q60 - 61'(sq_r);
  end

  // sin(omega): digit by digit square root, one digit per stage
  for (genvar k = 0; k < SQRT_N; k++) begin : g_sqrt
    logic [61:0] n_in;
    logic [61:0] r_in;
    logic [61:0] bitv;
    logic [61:0] trial;
    logic [61:0] n_nxt;
    logic [61:0] r_nxt;
    if (k == 0) begin : g_first
      assign n_in = {1'b0, rad_r};
      assign r_in = '0;
    end else begin : g_next
      assign n_in = rt_n_r[k-1];
      assign r_in = rt_q_r[k-1];
    end
    assign bitv  = 62'd1 << (60 - 2 * k);
    assign trial = r_in + bitv;
    always_comb begin
      if (n_in >= trial) begin
        n_nxt = n_in - trial;
        r_nxt = (r_in >> 1) + bitv;
      end else begin
        n_nxt = n_in;
        r_nxt = r_in >> 1;
      end
    end
    always_ff @(posedge clk) begin
      rt_n_r[k] <= n_nxt;
      rt_q_r[k] <= r_nxt;
    end
  end

  assign sinom = rt_q_r[SQRT_N-1][30:0];

  // omega: cordic vectoring of (cos, sin), one step per stage
  for (genvar i = 0; i < CORDIC_N; i++) begin : g_vec
    logic signed [33:0] x_in;
    logic signed [33:0] y_in;
    logic signed [33:0] z_in;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] at;
    if (i == 0) begin : g_first
      assign x_in = $signed({4'b0, side_r[ST_VEC0-1].c30});
      assign y_in = $signed({3'b0, sinom});
      assign z_in = '0;
    end else begin : g_next
      assign x_in = vx_r[i-1];
      assign y_in = vy_r[i-1];
      assign z_in = vz_r[i-1];
    end
    assign dx = y_in >>> i;
    assign dy = x_in >>> i;
    assign at = $signed({4'b0, ATAN_Q30[i]});
    always_ff @(posedge clk) begin
      if (!y_in[33]) begin
        vx_r[i] <= x_in + dx;
        vy_r[i] <= y_in - dy;
        vz_r[i] <= z_in + at;
      end else begin
        vx_r[i] <= x_in - dx;
        vy_r[i] <= y_in + dy;
        vz_r[i] <= z_in - at;
      end
    end
  end

  // partial angles (1-t)omega and t omega
  assign w0  = 17'(BLEND_ONE) - 17'(side_r[ST_ANG-1].t);
  assign w1  = 17'(side_r[ST_ANG-1].t);
  assign ap0 = $signed({1'b0, w0}) * vz_r[CORDIC_N-1];
  assign ap1 = $signed({1'b0, w1}) * vz_r[CORDIC_N-1];

  always_ff @(posedge clk) begin
    ang_r[0] <= 36'(ap0 >>> 15);
    ang_r[1] <= 36'(ap1 >>> 15);
  end

  // sines: two cordic rotation lanes, one step per stage
  for (genvar l = 0; l < 2; l++) begin : g_lane
    for (genvar i = 0; i < CORDIC_N; i++) begin : g_rot
      logic signed [33:0] x_in;
      logic signed [33:0] y_in;
      logic signed [35:0] z_in;
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic signed [35:0] at;
      if (i == 0) begin : g_first
        assign x_in = CORDIC_GAIN;
        assign y_in = '0;
        assign z_in = ang_r[l];
      end else begin : g_next
        assign x_in = rx_r[l][i-1];
        assign y_in = ry_r[l][i-1];
        assign z_in = rz_r[l][i-1];
      end
      assign dx = y_in >>> i;
      assign dy = x_in >>> i;
      assign at = $signed({6'b0, ATAN_Q30[i]});
      always_ff @(posedge clk) begin
        if (!z_in[35]) begin
          rx_r[l][i] <= x_in - dx;
          ry_r[l][i] <= y_in + dy;
          rz_r[l][i] <= z_in - at;
        end else begin
          rx_r[l][i] <= x_in + dx;
          ry_r[l][i] <= y_in - dy;
          rz_r[l][i] <= z_in + at;
        end
      end
    end

    // clamp the sine to [0, sin(omega)]
    always_comb begin
      if (ry_r[l][CORDIC_N-1][33]) begin
        clamp_nxt[l] = '0;
      end else if (ry_r[l][CORDIC_N-1] > $signed({3'b0, side_r[ST_CLAMP-1].sinom})) begin
        clamp_nxt[l] = side_r[ST_CLAMP-1].sinom;
      end else begin
        clamp_nxt[l] = ry_r[l][CORDIC_N-1][30:0];
      end
    end

    always_ff @(posedge clk) begin
      clamp_r[l] <= clamp_nxt[l];
    end

    // weight: restoring divide by sin(omega), one quotient bit per stage
    for (genvar k = 0; k < DIV_N; k++) begin : g_div
      logic [31:0] rem_in;
      logic [30:0] q_in;
      logic [31:0] dv;
      logic        ge;
      logic [31:0] rem_sub;
      if (k == 0) begin : g_first
        assign rem_in = {1'b0, clamp_r[l]};
        assign q_in   = '0;
      end else begin : g_next
        assign rem_in = dr_r[l][k-1];
        assign q_in   = dq_r[l][k-1];
      end
      assign dv      = {1'b0, side_r[ST_DIV0+k-1].sinom};
      assign ge      = (rem_in >= dv);
      assign rem_sub = ge ? (rem_in - dv) : rem_in;
      always_ff @(posedge clk) begin
        dr_r[l][k] <= {rem_sub[30:0], 1'b0};
        dq_r[l][k] <= {q_in[29:0], ge};
      end
    end
  end

  // weight select: linear pair or slerp quotients
  assign wk0 = 17'(BLEND_ONE) - 17'(side_r[ST_K-1].t);

  always_ff @(posedge clk) begin
    if (side_r[ST_K-1].lin) begin
      k_r[0] <= {wk0[15:0], 15'b0};
      k_r[1] <= {side_r[ST_K-1].t, 15'b0};
    end else begin
      k_r[0] <= dq_r[0][DIV_N-1];
      k_r[1] <= dq_r[1][DIV_N-1];
    end
  end

  // blend products, rounding sum, saturation
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      acc_sum[j] = 50'(m_r[j][0]) + 50'(m_r[j][1]) + ROUND_HALF;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      m_r[j][0] <= $signed({1'b0, k_r[0]}) * $signed(side_r[ST_MUL-1].a[j]);
      m_r[j][1] <= $signed({1'b0, k_r[1]}) * $signed(side_r[ST_MUL-1].b[j]);
      acc_r[j]  <= 20'(acc_sum[j] >>> 30);
      if (acc_r[j] > 20'sd32767) begin
        out_r[j] <= 16'sh7fff;
      end else if (acc_r[j] < -20'sd32768) begin
        out_r[j] <= 16'sh8000;
      end else begin
        out_r[j] <= acc_r[j][COMP_BITS-1:0];
      end
    end
  end

  assign out_valid = vld_r[ST_SAT];
  assign out_w     = out_r[0];
  assign out_x     = out_r[1];
  assign out_y     = out_r[2];
  assign out_z     = out_r[3];

endmodule

`default_nettype wire

// ===== rtl/qslerp_chk.sv =====
// port checker for the quaternion slerp and its bind
`default_nettype none
`include "quaternion_slerp_defines.svh"

module qslerp_chk import qslerp_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // every accepted beat is followed by its result under out_valid
  `QS_CHK(a_lat_fwd, (start && !busy) |-> ##LATENCY out_valid)
  // no result without an accepted beat before it
  `QS_CHK(a_lat_src, out_valid |-> $past(start && !busy, LATENCY))
  // busy covers reset and the cycle after release
  `QS_CHK_RST(a_rst_busy, !rst_n |-> busy)
  `QS_CHK(a_rel_busy, $rose(rst_n) |-> busy)

endmodule

bind quaternion_slerp qslerp_chk u_chk (.*);

`default_nettype wire
